>>> rtl/poe_pbm_pkg.sv
// Shared constants, codes and word types of the PoE power budget manager.
package poe_pbm_pkg;

  localparam int NUM_PORTS = 8;
  localparam int IDX_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam int PORT_W  = 3;
  localparam int POWER_W = 17;
  localparam int PRIO_W  = 8;
  localparam int SUM_W   = 20;
  localparam int HYST_W  = 16;
  localparam int CAUSE_W = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 1'b1;

  localparam logic [SUM_W-1:0]  TOTAL_RESET = 20'd60000;
  localparam logic [HYST_W-1:0] HYST_RESET  = 16'd2000;

  localparam logic [CAUSE_W-1:0] CAUSE_OWN    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_SHED   = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_REEN   = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_FORCED = 2'd3;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  // For a subtract, carry is the borrow: set when a is below b.
  typedef struct packed {
    logic             carry;
    logic [SUM_W-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [PORT_W-1:0]  port_number;
    logic [POWER_W-1:0] power_mw;
    logic [POWER_W-1:0] port_budget_mw;
    logic [PRIO_W-1:0]  prio_level;
    logic               port_open;
    logic               forced_mode;
    logic               enable_request;
    logic               last_port;
  } pbm_in_t;

  typedef struct packed {
    logic [PORT_W-1:0]  action_port;
    logic               power_on;
    logic [CAUSE_W-1:0] cause;
    logic               last_action;
  } pbm_out_t;

endpackage

>>> rtl/poe_pbm_alu.sv
// Shared add and subtract unit with carry and borrow out.
module poe_pbm_alu import poe_pbm_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [SUM_W:0] wide;

  always_comb begin
    case (req.op)
      ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      default: wide = '0;
    endcase
    rsp.carry = wide[SUM_W];
    rsp.res   = wide[SUM_W-1:0];
  end

endmodule

>>> rtl/poe_power_budget_manager.sv
// Top level of the PoE power budget manager: sequencer, port state and output stage.
//
//   channel  | signals                     | word / data
//   ---------+-----------------------------+---------------------------
//   input    | in_valid, in_stall          | in_word  (pbm_in_t)
//   output   | out_valid, out_stall        | out_word (pbm_out_t)
//   config   | cfg_we, cfg_index           | cfg_data (total, hysteresis)
//
// A non-final word: accept, own-budget compare and, if in range and within budget, sum add.
// A word that ends a scan then runs the end-of-scan checks and port walks.
// All compares and adds go through one shared adder, one operation per cycle.
// A stalled output holds the sequencer only when a second result is ready to move.
// Reset is synchronous; it restores budget, margin, over-budget marks and permissions at once.
module poe_power_budget_manager import poe_pbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pbm_in_t               in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pbm_out_t              out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_OWN    = 10'b0000000010,
    S_ADD    = 10'b0000000100,
    S_LIMIT  = 10'b0000001000,
    S_MARGIN = 10'b0000010000,
    S_HYST   = 10'b0000100000,
    S_SHED   = 10'b0001000000,
    S_REEN   = 10'b0010000000,
    S_PICK   = 10'b0100000000,
    S_FORCE  = 10'b1000000000
  } state_t;

  // The flush state shares the idle code space only in name; keep it separate.
  typedef enum logic [0:0] {
    FL_NONE = 1'b0,
    FL_DONE = 1'b1
  } flush_t;

  state_t              state;
  flush_t              flush;
  pbm_in_t             item;
  logic [SUM_W-1:0]    total_limit;
  logic [HYST_W-1:0]   hysteresis;
  logic [SUM_W-1:0]    power_sum;
  logic [SUM_W-1:0]    margin_sum;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    pick;
  logic [PRIO_W-1:0]   best;
  logic                pick_valid;
  logic                shed_mode;
  pbm_out_t            pend;
  logic                pend_valid;

  logic [NUM_PORTS-1:0] overbudget_mark;
  logic [NUM_PORTS-1:0] enable_permit;
  logic [NUM_PORTS-1:0] open_seen;
  logic [NUM_PORTS-1:0] forced_on_mark;
  logic [PRIO_W-1:0]    stored_priority [NUM_PORTS];

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [IDX_W-1:0] item_idx;
  logic [IDX_W-1:0] in_idx;
  logic             item_in_range;
  logic             in_in_range;
  logic             walk_last;
  logic             can_push;
  logic             emit_req;
  logic             emit_ok;
  logic             emit_fire;
  logic             flush_fire;
  logic             shed_better;
  logic             reen_cand;
  pbm_out_t         emit_word;

  poe_pbm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall      = (state != S_IDLE) || (flush == FL_DONE);
  assign item_idx      = IDX_W'(item.port_number);
  assign in_idx        = IDX_W'(in_word.port_number);
  assign item_in_range = int'(item.port_number) < NUM_PORTS;
  assign in_in_range   = int'(in_word.port_number) < NUM_PORTS;
  assign walk_last     = (idx == IDX_W'(NUM_PORTS - 1));
  assign can_push      = !out_valid || !out_stall;
  assign emit_ok       = !pend_valid || can_push;
  assign emit_fire     = emit_req && emit_ok;
  assign flush_fire    = (flush == FL_DONE) && pend_valid && can_push;
  assign shed_better   = !pick_valid || alu_rsp.carry;
  assign reen_cand     = !open_seen[idx] && overbudget_mark[idx] && enable_permit[idx] &&
                         (!pick_valid || alu_rsp.carry);

  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      S_OWN: begin
        alu_req.a = SUM_W'(item.port_budget_mw);
        alu_req.b = SUM_W'(item.power_mw);
      end
      S_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = power_sum;
        alu_req.b  = SUM_W'(item.power_mw);
      end
      S_LIMIT: begin
        alu_req.a = total_limit;
        alu_req.b = power_sum;
      end
      S_MARGIN: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = power_sum;
        alu_req.b  = SUM_W'(hysteresis);
      end
      S_HYST: begin
        alu_req.a = total_limit;
        alu_req.b = margin_sum;
      end
      S_SHED: begin
        // Borrow means this port has a larger priority number than the best so far.
        alu_req.a = SUM_W'(best);
        alu_req.b = SUM_W'(stored_priority[idx]);
      end
      S_REEN: begin
        alu_req.a = SUM_W'(stored_priority[idx]);
        alu_req.b = SUM_W'(best);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_word = '0;
    case (state)
      S_OWN: begin
        emit_req              = item_in_range && alu_rsp.carry;
        emit_word.action_port = item.port_number;
        emit_word.power_on    = 1'b0;
        emit_word.cause       = CAUSE_OWN;
      end
      S_PICK: begin
        emit_req              = 1'b1;
        emit_word.action_port = PORT_W'(pick);
        emit_word.power_on    = !shed_mode;
        emit_word.cause       = shed_mode ? CAUSE_SHED : CAUSE_REEN;
      end
      S_FORCE: begin
        emit_req              = forced_on_mark[idx];
        emit_word.action_port = PORT_W'(idx);
        emit_word.power_on    = 1'b1;
        emit_word.cause       = CAUSE_FORCED;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      flush           <= FL_NONE;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
      power_sum       <= '0;
      overbudget_mark <= '0;
      enable_permit   <= '1;
      total_limit     <= TOTAL_RESET;
      hysteresis      <= HYST_RESET;
      pick_valid      <= 1'b0;
      shed_mode       <= 1'b0;
      idx             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_BUDGET: total_limit <= cfg_data;
          REG_HYSTERESIS:   hysteresis  <= cfg_data[HYST_W-1:0];
          default:          total_limit <= total_limit;
        endcase
      end

      // A held result moves out only once the next one exists or the word is done,
      // so the last one can carry its end mark.
      if (emit_fire && pend_valid) begin
        out_word  <= pend;
        out_valid <= 1'b1;
      end else if (flush_fire) begin
        out_word  <= '{action_port: pend.action_port, power_on: pend.power_on,
                       cause: pend.cause, last_action: 1'b1};
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (emit_fire) begin
        pend       <= emit_word;
        pend_valid <= 1'b1;
      end else if (flush_fire) begin
        pend_valid <= 1'b0;
      end

      if (flush == FL_DONE && (!pend_valid || can_push)) begin
        flush <= FL_NONE;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_word;
            if (in_in_range) begin
              stored_priority[in_idx] <= in_word.prio_level;
              open_seen[in_idx]       <= in_word.port_open;
              forced_on_mark[in_idx]  <= in_word.forced_mode & in_word.enable_request;
            end
            state <= S_OWN;
          end
        end
        S_OWN: begin
          if (!item_in_range) begin
            state <= item.last_port ? S_LIMIT : S_IDLE;
          end else if (alu_rsp.carry) begin
            overbudget_mark[item_idx] <= 1'b1;
            if (item.last_port) begin
              state <= S_LIMIT;
            end else begin
              state <= S_IDLE;
              flush <= FL_DONE;
            end
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          power_sum <= alu_rsp.carry ? '1 : alu_rsp.res;
          state     <= item.last_port ? S_LIMIT : S_IDLE;
        end
        S_LIMIT: begin
          idx        <= '0;
          pick_valid <= 1'b0;
          if (alu_rsp.carry) begin
            shed_mode <= 1'b1;
            state     <= S_SHED;
          end else begin
            state <= S_MARGIN;
          end
        end
        S_MARGIN: begin
          // A carry here puts sum plus margin above any budget value.
          if (alu_rsp.carry) begin
            state <= S_FORCE;
          end else begin
            margin_sum <= alu_rsp.res;
            state      <= S_HYST;
          end
        end
        S_HYST: begin
          shed_mode <= 1'b0;
          state     <= alu_rsp.carry ? S_FORCE : S_REEN;
        end
        S_SHED: begin
          if (shed_better) begin
            pick       <= idx;
            best       <= stored_priority[idx];
            pick_valid <= 1'b1;
          end
          if (walk_last) begin
            state <= S_PICK;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_REEN: begin
          if (open_seen[idx]) begin
            if (overbudget_mark[idx]) begin
              enable_permit[idx] <= 1'b1;
            end
          end else if (reen_cand) begin
            pick       <= idx;
            best       <= stored_priority[idx];
            pick_valid <= 1'b1;
          end
          if (walk_last) begin
            idx   <= '0;
            state <= (pick_valid || (!open_seen[idx] && reen_cand)) ? S_PICK : S_FORCE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_PICK: begin
          if (emit_ok) begin
            if (shed_mode) begin
              enable_permit[pick]   <= 1'b0;
              overbudget_mark[pick] <= 1'b1;
            end else begin
              overbudget_mark[pick] <= 1'b0;
            end
            idx   <= '0;
            state <= S_FORCE;
          end
        end
        S_FORCE: begin
          if (!forced_on_mark[idx] || emit_ok) begin
            if (walk_last) begin
              power_sum <= '0;
              state     <= S_IDLE;
              flush     <= FL_DONE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !pend_valid)
    else $error("block ready while a result is still held");

  a_accept_own: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_OWN))
    else $error("accepted word did not start the own-budget check");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    flush_fire |=> (out_valid && out_word.last_action))
    else $error("final result of a word lacks its end mark");

  a_shed_bars: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && shed_mode && emit_ok) |=>
      (!enable_permit[$past(pick)] && overbudget_mark[$past(pick)]))
    else $error("shed port was not barred and marked");
`endif

endmodule
